FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files; the top-level core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked on every rising clock edge outside reset.
`define PDTS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication, checked outside reset.
`define PDTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/pdts_pkg.sv
// Types, constants and the pad table of the PWM duty to timer setup block.
package pdts_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int CHAN_W       = 2;
   localparam int FREQ_W       = 24;
   localparam int PAD_W        = 6;
   localparam int DUTY_W       = 14;
   localparam int PERIOD_W     = 16;
   localparam int PROD_W       = DUTY_W + PERIOD_W;
   localparam int RES_W        = 2;
   localparam int TIMER_W      = 3;

   localparam int unsigned CLOCK_HZ   = 12000000;
   localparam int unsigned PERIOD_MAX = 32'h0000FFFF;
   localparam int unsigned PERIOD_MIN = 3;

   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_DUTY = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_ARG = 2'd1;
   localparam logic [1:0] STATUS_NO_PAD  = 2'd2;

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_LOW    = 2'd1;
   localparam logic [1:0] MODE_HIGH   = 2'd2;

   localparam logic [RES_W-1:0] RES_8  = 2'd0;
   localparam logic [RES_W-1:0] RES_10 = 2'd1;
   localparam logic [RES_W-1:0] RES_12 = 2'd2;
   localparam logic [RES_W-1:0] RES_14 = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [CHAN_W-1:0] channel;
      logic [FREQ_W-1:0] frequency_hz;
      logic [PAD_W-1:0]  pad_number;
      logic [DUTY_W-1:0] duty;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [TIMER_W-1:0]  timer_number;
      logic                use_half_b;
      logic [1:0]          output_mode;
      logic [PERIOD_W-1:0] period_ticks;
      logic [PERIOD_W-1:0] on_ticks;
      logic                start_timer;
   } rsp_word_type;

   typedef struct packed {
      logic               found;
      logic [TIMER_W-1:0] timer;
      logic               half_b;
   } pad_hit_type;

   function automatic logic [DUTY_W-1:0] max_duty(input logic [RES_W-1:0] mode);
      logic [DUTY_W-1:0] m;
      unique case (mode)
         RES_8:   m = 14'd255;
         RES_10:  m = 14'd1023;
         RES_12:  m = 14'd4095;
         RES_14:  m = 14'd16383;
         default: m = 14'd255;
      endcase
      return m;
   endfunction

   function automatic pad_hit_type pad_lookup(input logic [PAD_W-1:0] pad);
      pad_hit_type h;
      h.found = 1'b1;
      unique case (pad)
         6'd12: begin h.timer = 3'd0; h.half_b = 1'b0; end
         6'd25: begin h.timer = 3'd0; h.half_b = 1'b0; end
         6'd13: begin h.timer = 3'd0; h.half_b = 1'b1; end
         6'd26: begin h.timer = 3'd0; h.half_b = 1'b1; end
         6'd18: begin h.timer = 3'd1; h.half_b = 1'b0; end
         6'd27: begin h.timer = 3'd1; h.half_b = 1'b0; end
         6'd19: begin h.timer = 3'd1; h.half_b = 1'b1; end
         6'd28: begin h.timer = 3'd1; h.half_b = 1'b1; end
         6'd5:  begin h.timer = 3'd2; h.half_b = 1'b0; end
         6'd29: begin h.timer = 3'd2; h.half_b = 1'b0; end
         6'd6:  begin h.timer = 3'd2; h.half_b = 1'b1; end
         6'd30: begin h.timer = 3'd2; h.half_b = 1'b1; end
         6'd22: begin h.timer = 3'd3; h.half_b = 1'b0; end
         6'd31: begin h.timer = 3'd3; h.half_b = 1'b0; end
         6'd23: begin h.timer = 3'd3; h.half_b = 1'b1; end
         6'd32: begin h.timer = 3'd3; h.half_b = 1'b1; end
         6'd42: begin h.timer = 3'd4; h.half_b = 1'b0; end
         6'd4:  begin h.timer = 3'd4; h.half_b = 1'b0; end
         6'd43: begin h.timer = 3'd4; h.half_b = 1'b1; end
         6'd7:  begin h.timer = 3'd4; h.half_b = 1'b1; end
         6'd44: begin h.timer = 3'd5; h.half_b = 1'b0; end
         6'd24: begin h.timer = 3'd5; h.half_b = 1'b0; end
         6'd45: begin h.timer = 3'd5; h.half_b = 1'b1; end
         6'd33: begin h.timer = 3'd5; h.half_b = 1'b1; end
         6'd46: begin h.timer = 3'd6; h.half_b = 1'b0; end
         6'd39: begin h.timer = 3'd4; h.half_b = 1'b1; end
         6'd47: begin h.timer = 3'd6; h.half_b = 1'b1; end
         6'd35: begin h.timer = 3'd6; h.half_b = 1'b1; end
         6'd48: begin h.timer = 3'd7; h.half_b = 1'b0; end
         6'd37: begin h.timer = 3'd5; h.half_b = 1'b1; end
         6'd49: begin h.timer = 3'd7; h.half_b = 1'b1; end
         6'd11: begin h.timer = 3'd7; h.half_b = 1'b1; end
         default: begin h.found = 1'b0; h.timer = 3'd0; h.half_b = 1'b0; end
      endcase
      return h;
   endfunction

endpackage

FILE: rtl/pdts_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pdts_div #(
   parameter int DIVIDEND_W = pdts_pkg::PROD_W,
   parameter int DIVISOR_W  = pdts_pkg::FREQ_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] q_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVIDEND_W-1:0] q_in;

   always_comb begin
      trial  = {rem_ff, q_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = ~diff[DIVISOR_W];
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      q_in   = {q_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
            q_ff    <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            q_ff   <= q_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: rtl/pdts_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pdts_mul #(
   parameter int A_W = pdts_pkg::DUTY_W,
   parameter int B_W = pdts_pkg::PERIOD_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   a,
   input  logic [B_W-1:0]   b,
   output logic             done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [P_W-1:0]   acc_ff;
   logic [P_W-1:0]   mcand_ff;
   logic [B_W-1:0]   mplier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= CNT_W'(B_W);
            acc_ff    <= '0;
            mcand_ff  <= P_W'(a);
            mplier_ff <= b;
         end else if (busy_ff) begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[P_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[B_W-1:1]};
            cnt_ff    <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/pwm_duty_to_timer_setup_core.sv
// Top level of the PWM duty to timer setup block: channel table, sequencer, result register.
//
//   port group   dir   handshake          word
//   req_         in    req_valid/stall    pdts_pkg::req_word_type
//   rsp_         out   rsp_valid/stall    pdts_pkg::rsp_word_type
//   csr_         in    csr_valid/ready    resolution mode, 2 bits
//
// An init word or an argument error caught at acceptance goes straight to the finish state.
// A period out of range ends the word after the first division. A full duty word runs two
// 30-step restoring divisions and a 16-step shift-add multiply, each with a load and a
// hand-off step, then loads the result. A result held under rsp_stall delays the next word.
// req_stall is high from acceptance until the result moves into the output register.
// Synchronous reset clears the channel table, the resolution register and all control.
`include "assert_macros.svh"

module pwm_duty_to_timer_setup_core #(
   parameter int CHANNELS = pdts_pkg::CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pdts_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pdts_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [pdts_pkg::RES_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_PERIOD,
      ST_MUL,
      ST_DIV_ON,
      ST_FINISH
   } state_type;

   state_type                          state_ff;
   logic [pdts_pkg::FREQ_W-1:0]        freq_tab_ff [CHANNELS];
   logic [pdts_pkg::PAD_W-1:0]         pad_tab_ff  [CHANNELS];
   logic [pdts_pkg::RES_W-1:0]         resolution_ff;
   logic [pdts_pkg::DUTY_W-1:0]        duty_ff;
   logic [pdts_pkg::PAD_W-1:0]         pad_ff;
   logic [pdts_pkg::PERIOD_W-1:0]      period_ff;
   logic                               div_start_ff;
   logic                               mul_start_ff;
   logic [pdts_pkg::PROD_W-1:0]        div_dividend_ff;
   logic [pdts_pkg::FREQ_W-1:0]        div_divisor_ff;
   pdts_pkg::rsp_word_type             res_ff;
   pdts_pkg::rsp_word_type             rsp_word_ff;
   logic                               rsp_valid_ff;

   logic                               div_done;
   logic [pdts_pkg::PROD_W-1:0]        div_quotient;
   logic                               mul_done;
   logic [pdts_pkg::PROD_W-1:0]        mul_product;

   logic [pdts_pkg::FREQ_W-1:0]        freq_sel;
   logic [pdts_pkg::PAD_W-1:0]         pad_sel;
   logic                               chan_ok;
   logic [pdts_pkg::DUTY_W-1:0]        maxd;
   logic [pdts_pkg::PERIOD_W-1:0]      on_val;
   pdts_pkg::pad_hit_type              hit;
   logic                               out_free;

   logic                               req_take;
   logic                               rsp_err;
   logic                               rsp_err_clean;
   logic                               rsp_start;
   logic                               rsp_start_ok;

   always_comb begin
      freq_sel = '0;
      pad_sel  = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (32'(req_word.channel) == i) begin
            freq_sel = freq_tab_ff[i];
            pad_sel  = pad_tab_ff[i];
         end
      end
      chan_ok  = 32'(req_word.channel) < CHANNELS;
      maxd     = pdts_pkg::max_duty(resolution_ff);
      on_val   = div_quotient[pdts_pkg::PERIOD_W-1:0];
      hit      = pdts_pkg::pad_lookup(pad_ff);
      out_free = ~rsp_valid_ff | ~rsp_stall;
   end

   pdts_div #(
      .DIVIDEND_W (pdts_pkg::PROD_W),
      .DIVISOR_W  (pdts_pkg::FREQ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend_ff),
      .divisor  (div_divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   pdts_mul #(
      .A_W (pdts_pkg::DUTY_W),
      .B_W (pdts_pkg::PERIOD_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (duty_ff),
      .b       (period_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         resolution_ff <= '0;
         div_start_ff  <= 1'b0;
         mul_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            freq_tab_ff[i] <= '0;
            pad_tab_ff[i]  <= '0;
         end
      end else begin
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         if (csr_valid) begin
            resolution_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  res_ff  <= '0;
                  duty_ff <= req_word.duty;
                  pad_ff  <= pad_sel;
                  if (req_word.cmd == pdts_pkg::CMD_INIT) begin
                     for (int i = 0; i < CHANNELS; i++) begin
                        if (32'(req_word.channel) == i) begin
                           freq_tab_ff[i] <= req_word.frequency_hz;
                           pad_tab_ff[i]  <= req_word.pad_number;
                        end
                     end
                     state_ff <= ST_FINISH;
                  end else if (!chan_ok || freq_sel == '0 || req_word.duty > maxd) begin
                     res_ff.status <= pdts_pkg::STATUS_BAD_ARG;
                     state_ff      <= ST_FINISH;
                  end else begin
                     div_dividend_ff <= pdts_pkg::PROD_W'(pdts_pkg::CLOCK_HZ);
                     div_divisor_ff  <= freq_sel;
                     div_start_ff    <= 1'b1;
                     state_ff        <= ST_DIV_PERIOD;
                  end
               end
            end
            ST_DIV_PERIOD: begin
               if (div_done) begin
                  if (div_quotient > pdts_pkg::PROD_W'(pdts_pkg::PERIOD_MAX) ||
                      div_quotient < pdts_pkg::PROD_W'(pdts_pkg::PERIOD_MIN)) begin
                     res_ff.status <= pdts_pkg::STATUS_BAD_ARG;
                     state_ff      <= ST_FINISH;
                  end else begin
                     period_ff    <= div_quotient[pdts_pkg::PERIOD_W-1:0];
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  div_dividend_ff <= mul_product;
                  div_divisor_ff  <= pdts_pkg::FREQ_W'(maxd);
                  div_start_ff    <= 1'b1;
                  state_ff        <= ST_DIV_ON;
               end
            end
            ST_DIV_ON: begin
               if (div_done) begin
                  if (!hit.found) begin
                     res_ff.status <= pdts_pkg::STATUS_NO_PAD;
                  end else begin
                     res_ff.status       <= pdts_pkg::STATUS_OK;
                     res_ff.timer_number <= hit.timer;
                     res_ff.use_half_b   <= hit.half_b;
                     res_ff.period_ticks <= period_ff;
                     res_ff.on_ticks     <= on_val;
                     priority if (on_val == '0) begin
                        res_ff.output_mode <= pdts_pkg::MODE_LOW;
                        res_ff.start_timer <= 1'b0;
                     end else if (on_val == period_ff) begin
                        res_ff.output_mode <= pdts_pkg::MODE_HIGH;
                        res_ff.start_timer <= 1'b0;
                     end else begin
                        res_ff.output_mode <= pdts_pkg::MODE_NORMAL;
                        res_ff.start_timer <= 1'b1;
                     end
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

   assign req_take      = req_valid && !req_stall;
   assign rsp_err       = rsp_valid && (rsp_word.status != pdts_pkg::STATUS_OK);
   assign rsp_err_clean = (rsp_word.period_ticks == '0) && (rsp_word.on_ticks == '0) &&
                          !rsp_word.start_timer &&
                          (rsp_word.output_mode == pdts_pkg::MODE_NORMAL);
   assign rsp_start     = rsp_valid && rsp_word.start_timer;
   assign rsp_start_ok  = (rsp_word.on_ticks != '0) &&
                          (rsp_word.on_ticks < rsp_word.period_ticks) &&
                          (rsp_word.output_mode == pdts_pkg::MODE_NORMAL);

   `PDTS_ASSERT(a_one_at_a_time, clock, reset, req_take |=> req_stall, "input not closed")
   `PDTS_ASSERT_IMPL(a_error_clean, clock, reset, rsp_err, rsp_err_clean, "error word has data")
   `PDTS_ASSERT_IMPL(a_start_range, clock, reset, rsp_start, rsp_start_ok, "forced output started")

endmodule
